@@ src/rgl_pkg.sv @@
// Shared types and constants of the range gradient localizer.
package rgl_pkg;

    localparam int CNT_W      = 6;
    localparam int ROOT_STEPS = 33;
    localparam int DIV_STEPS  = 24;

    localparam logic [31:0] OWN_ID_RESET  = 32'd0;
    localparam logic [31:0] STEP_RESET    = 32'd65536;
    localparam logic [31:0] THR_RESET     = 32'd655;
    localparam logic [31:0] ONE_Q16       = 32'h0001_0000;
    localparam logic [7:0]  SKIP_LIMIT    = 8'h80;
    localparam logic [79:0] STEP_CAP      = 80'h1_0000_0000_00;

    localparam logic [1:0] CFG_OWN_ID    = 2'd0;
    localparam logic [1:0] CFG_RAND_SKIP = 2'd1;
    localparam logic [1:0] CFG_STEP      = 2'd2;
    localparam logic [1:0] CFG_THRESHOLD = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SQX,
        OP_SQY,
        OP_RINIT,
        OP_ROOT,
        OP_PRX,
        OP_PRY,
        OP_DIV,
        OP_ACC,
        OP_ULO,
        OP_UHI,
        OP_UFIN,
        OP_CLR
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
        logic axis;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic skip;
    } t_status;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] own_x;
        logic signed [31:0] own_y;
        logic [31:0]        neighbor_id;
        logic [15:0]        measured_distance;
        logic               target_known;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic [7:0]         random_byte;
    } t_in_word;

endpackage

@@ src/rgl_if.sv @@
// Handshake channel interfaces for input and result words.
interface rgl_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] own_x;
    logic signed [31:0] own_y;
    logic [31:0]        neighbor_id;
    logic [15:0]        measured_distance;
    logic               target_known;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic [7:0]         random_byte;

    modport source (output valid, kind, own_x, own_y, neighbor_id, measured_distance,
                    target_known, target_x, target_y, random_byte, input ready);
    modport sink (input valid, kind, own_x, own_y, neighbor_id, measured_distance,
                  target_known, target_x, target_y, random_byte, output ready);
endinterface

interface rgl_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic               converged;

    modport source (output valid, new_x, new_y, converged, input ready);
    modport sink (input valid, new_x, new_y, converged, output ready);
endinterface

@@ src/range_gradient_localizer_unit.sv @@
// Top level of the range gradient localizer.
// Neighbor word: the next word is accepted after the 33-step root and the 24-step divide.
// Skipped neighbor word: the next word is accepted after the check state. Update word: the
// result is valid once both axes have used the shared 32x32 multiplier, four times in all; it
// waits while a result is pending.
// Reset (synchronous, active low) clears the gradient and loads register defaults.
module range_gradient_localizer_unit #(
    parameter int GRADIENT_WIDTH = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rgl_in_if.sink      i_in_ch,
    rgl_out_if.source   o_out_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    rgl_pkg::t_cmd     cmd;
    rgl_pkg::t_status  status;
    rgl_pkg::t_in_word in_word;

    assign in_word.kind              = i_in_ch.kind;
    assign in_word.own_x             = i_in_ch.own_x;
    assign in_word.own_y             = i_in_ch.own_y;
    assign in_word.neighbor_id       = i_in_ch.neighbor_id;
    assign in_word.measured_distance = i_in_ch.measured_distance;
    assign in_word.target_known      = i_in_ch.target_known;
    assign in_word.target_x          = i_in_ch.target_x;
    assign in_word.target_y          = i_in_ch.target_y;
    assign in_word.random_byte       = i_in_ch.random_byte;

    rgl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (i_in_ch.ready),
        .i_out_ready (o_out_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rgl_datapath #(
        .GRADIENT_WIDTH (GRADIENT_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_word      (in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_new_x     (o_out_ch.new_x),
        .o_new_y     (o_out_ch.new_y),
        .o_converged (o_out_ch.converged)
    );

    a_one_word_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && i_in_ch.ready) |=> !i_in_ch.ready)
        else $error("input accepted while a word is in progress");

    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_ch.valid) |-> status.kind)
        else $error("result raised by a neighbor word");

    a_load_only_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> i_in_ch.ready)
        else $error("datapath load outside the idle state");

endmodule

@@ src/rgl_ctrl.sv @@
// Controller state machine sequencing the localizer datapath.
module rgl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  rgl_pkg::t_status i_status,
    output rgl_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SQX, S_SQY, S_RINIT, S_ROOT, S_PRX, S_PRY,
        S_DIV, S_ACC, S_UWAIT, S_ULO, S_UHI, S_UFIN, S_CLR
    } t_state;

    t_state                    r_state, n_state;
    logic [rgl_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_axis, n_axis;
    logic                      r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_axis      = r_axis;
        n_out_valid = r_out_valid;
        o_cmd.load  = 1'b0;
        o_cmd.op    = rgl_pkg::OP_NONE;
        o_cmd.axis  = r_axis;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.kind) begin
                    n_state = S_UWAIT;
                end else if (i_status.skip) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SQX;
                end
            end
            S_SQX: begin
                o_cmd.op = rgl_pkg::OP_SQX;
                n_state  = S_SQY;
            end
            S_SQY: begin
                o_cmd.op = rgl_pkg::OP_SQY;
                n_state  = S_RINIT;
            end
            S_RINIT: begin
                o_cmd.op = rgl_pkg::OP_RINIT;
                n_cnt    = '0;
                n_state  = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.op = rgl_pkg::OP_ROOT;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == rgl_pkg::CNT_W'(rgl_pkg::ROOT_STEPS - 1)) begin
                    n_state = S_PRX;
                end
            end
            S_PRX: begin
                o_cmd.op = rgl_pkg::OP_PRX;
                n_state  = S_PRY;
            end
            S_PRY: begin
                o_cmd.op = rgl_pkg::OP_PRY;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = rgl_pkg::OP_DIV;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == rgl_pkg::CNT_W'(rgl_pkg::DIV_STEPS - 1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.op = rgl_pkg::OP_ACC;
                n_state  = S_IDLE;
            end
            S_UWAIT: begin
                n_axis = 1'b0;
                if (!r_out_valid) begin
                    n_state = S_ULO;
                end
            end
            S_ULO: begin
                o_cmd.op = rgl_pkg::OP_ULO;
                n_state  = S_UHI;
            end
            S_UHI: begin
                o_cmd.op = rgl_pkg::OP_UHI;
                n_state  = S_UFIN;
            end
            S_UFIN: begin
                o_cmd.op = rgl_pkg::OP_UFIN;
                if (r_axis) begin
                    n_state = S_CLR;
                end else begin
                    n_axis  = 1'b1;
                    n_state = S_ULO;
                end
            end
            S_CLR: begin
                o_cmd.op    = rgl_pkg::OP_CLR;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ src/rgl_datapath.sv @@
// Datapath: distance root, range division, gradient accumulation, position update.
module rgl_datapath #(
    parameter int GRADIENT_WIDTH = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rgl_pkg::t_cmd      i_cmd,
    output rgl_pkg::t_status   o_status,
    input  rgl_pkg::t_in_word  i_word,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output logic signed [31:0] o_new_x,
    output logic signed [31:0] o_new_y,
    output logic               o_converged
);

    localparam int GW = GRADIENT_WIDTH;
    localparam int SW = ((GW > 34) ? GW : 34) + 1;
    localparam logic signed [SW-1:0] GMAX_S = SW'({1'b0, {(GW-1){1'b1}}});
    localparam logic signed [SW-1:0] GMIN_S = -GMAX_S - SW'(1);

    logic [31:0]          r_own_id, r_step, r_thr;
    logic                 r_rse;
    logic                 r_kind, r_skip;
    logic signed [31:0]   r_ox, r_oy;
    logic [31:0]          r_ax, r_ay;
    logic                 r_negx, r_negy;
    logic [23:0]          r_dist;
    logic [63:0]          r_prod, r_plo;
    logic [65:0]          r_sum;
    logic [32:0]          r_root;
    logic [34:0]          r_rem;
    logic [32:0]          r_remx, r_remy;
    logic [23:0]          r_qx, r_qy;
    logic signed [GW-1:0] r_gx, r_gy;
    logic signed [31:0]   r_outx, r_outy;
    logic                 r_convx, r_conv;

    logic signed [32:0] dxs, dys;
    logic               both_zero, load_skip;
    logic [31:0]        load_ax, load_ay;
    logic [31:0]        ma, mb;
    logic [63:0]        mul;
    logic [36:0]        rem_sh, trial;
    logic [32:0]        mag;
    logic [33:0]        rsx, rsy;
    logic signed [33:0] tx, ty, termx, termy;
    logic signed [GW-1:0] g;
    logic               gneg;
    logic [GW-1:0]      ua_g;
    logic [63:0]        ua;
    logic [95:0]        full;
    logic [40:0]        pcap;
    logic signed [31:0] pos;
    logic signed [42:0] rsum;
    logic signed [31:0] newv;
    logic signed [33:0] err;
    logic [33:0]        aerr;
    logic               conv;

    function automatic logic signed [GW-1:0] sat_add(input logic signed [GW-1:0] a,
                                                     input logic signed [33:0] t);
        logic signed [SW-1:0] s;
        s = SW'(a) + SW'(t);
        if (s > GMAX_S) begin
            return GMAX_S[GW-1:0];
        end else if (s < GMIN_S) begin
            return GMIN_S[GW-1:0];
        end
        return s[GW-1:0];
    endfunction

    always_comb begin
        dxs       = {i_word.own_x[31], i_word.own_x} - {i_word.target_x[31], i_word.target_x};
        dys       = {i_word.own_y[31], i_word.own_y} - {i_word.target_y[31], i_word.target_y};
        both_zero = (dxs == '0) && (dys == '0);
        load_ax   = both_zero ? rgl_pkg::ONE_Q16 : (dxs[32] ? 32'(-dxs) : dxs[31:0]);
        load_ay   = both_zero ? rgl_pkg::ONE_Q16 : (dys[32] ? 32'(-dys) : dys[31:0]);
        load_skip = (i_word.neighbor_id == r_own_id)
                 || (r_rse && (i_word.random_byte < rgl_pkg::SKIP_LIMIT))
                 || !i_word.target_known;
    end

    always_comb begin
        g    = i_cmd.axis ? r_gy : r_gx;
        gneg = g[GW-1];
        ua_g = gneg ? GW'(-g) : GW'(g);
        ua   = 64'(ua_g);
        case (i_cmd.op)
            rgl_pkg::OP_SQX: begin ma = r_ax;       mb = r_ax; end
            rgl_pkg::OP_SQY: begin ma = r_ay;       mb = r_ay; end
            rgl_pkg::OP_PRX: begin ma = r_ax;       mb = {8'b0, r_dist}; end
            rgl_pkg::OP_PRY: begin ma = r_ay;       mb = {8'b0, r_dist}; end
            rgl_pkg::OP_ULO: begin ma = ua[31:0];   mb = r_step; end
            rgl_pkg::OP_UHI: begin ma = ua[63:32];  mb = r_step; end
            default:         begin ma = '0;         mb = '0; end
        endcase
        mul = 64'(ma) * 64'(mb);
    end

    always_comb begin
        rem_sh = {r_rem, r_sum[65:64]};
        trial  = {2'b0, r_root, 2'b01};
        mag    = (r_root == '0) ? 33'd1 : r_root;
        rsx    = {r_remx, r_qx[23]};
        rsy    = {r_remy, r_qy[23]};
        tx     = $signed({2'b0, r_ax}) - $signed({10'b0, r_qx});
        ty     = $signed({2'b0, r_ay}) - $signed({10'b0, r_qy});
        termx  = r_negx ? -tx : tx;
        termy  = r_negy ? -ty : ty;
    end

    always_comb begin
        full = {r_prod, 32'b0} + {32'b0, r_plo};
        pcap = (full[95:16] > rgl_pkg::STEP_CAP) ? rgl_pkg::STEP_CAP[40:0] : full[56:16];
        pos  = i_cmd.axis ? r_oy : r_ox;
        rsum = gneg ? (43'(pos) + $signed({2'b0, pcap})) : (43'(pos) - $signed({2'b0, pcap}));
        if (rsum > 43'sd2147483647) begin
            newv = 32'sh7FFF_FFFF;
        end else if (rsum < -43'sd2147483648) begin
            newv = 32'sh8000_0000;
        end else begin
            newv = rsum[31:0];
        end
        err  = 34'(newv) - 34'(pos);
        aerr = err[33] ? 34'(-err) : 34'(err);
        conv = aerr < {2'b0, r_thr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= rgl_pkg::OWN_ID_RESET;
            r_rse    <= 1'b0;
            r_step   <= rgl_pkg::STEP_RESET;
            r_thr    <= rgl_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rgl_pkg::CFG_OWN_ID:    r_own_id <= i_cfg_data;
                rgl_pkg::CFG_RAND_SKIP: r_rse    <= i_cfg_data[0];
                rgl_pkg::CFG_STEP:      r_step   <= i_cfg_data;
                rgl_pkg::CFG_THRESHOLD: r_thr    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gx <= '0;
            r_gy <= '0;
        end else if (i_cmd.op == rgl_pkg::OP_ACC) begin
            r_gx <= sat_add(r_gx, termx);
            r_gy <= sat_add(r_gy, termy);
        end else if (i_cmd.op == rgl_pkg::OP_CLR) begin
            r_gx <= '0;
            r_gy <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_word.kind;
            r_skip <= load_skip;
            r_ox   <= i_word.own_x;
            r_oy   <= i_word.own_y;
            r_ax   <= load_ax;
            r_ay   <= load_ay;
            r_negx <= !both_zero && dxs[32];
            r_negy <= !both_zero && dys[32];
            r_dist <= {i_word.measured_distance, 8'b0};
        end
        case (i_cmd.op)
            rgl_pkg::OP_SQX: r_prod <= mul;
            rgl_pkg::OP_SQY: begin
                r_sum  <= {2'b0, r_prod};
                r_prod <= mul;
            end
            rgl_pkg::OP_RINIT: begin
                r_sum  <= r_sum + {2'b0, r_prod};
                r_root <= '0;
                r_rem  <= '0;
            end
            rgl_pkg::OP_ROOT: begin
                r_sum <= {r_sum[63:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= 35'(rem_sh - trial);
                    r_root <= {r_root[31:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh[34:0];
                    r_root <= {r_root[31:0], 1'b0};
                end
            end
            rgl_pkg::OP_PRX: begin
                r_remx <= {1'b0, mul[55:24]};
                r_qx   <= mul[23:0];
            end
            rgl_pkg::OP_PRY: begin
                r_remy <= {1'b0, mul[55:24]};
                r_qy   <= mul[23:0];
            end
            rgl_pkg::OP_DIV: begin
                if (rsx >= {1'b0, mag}) begin
                    r_remx <= 33'(rsx - {1'b0, mag});
                    r_qx   <= {r_qx[22:0], 1'b1};
                end else begin
                    r_remx <= rsx[32:0];
                    r_qx   <= {r_qx[22:0], 1'b0};
                end
                if (rsy >= {1'b0, mag}) begin
                    r_remy <= 33'(rsy - {1'b0, mag});
                    r_qy   <= {r_qy[22:0], 1'b1};
                end else begin
                    r_remy <= rsy[32:0];
                    r_qy   <= {r_qy[22:0], 1'b0};
                end
            end
            rgl_pkg::OP_ULO: r_prod <= mul;
            rgl_pkg::OP_UHI: begin
                r_plo  <= r_prod;
                r_prod <= mul;
            end
            rgl_pkg::OP_UFIN: begin
                if (i_cmd.axis) begin
                    r_outy <= newv;
                    r_conv <= r_convx && conv;
                end else begin
                    r_outx  <= newv;
                    r_convx <= conv;
                end
            end
            default: ;
        endcase
    end

    assign o_status.kind = r_kind;
    assign o_status.skip = r_skip;
    assign o_new_x       = r_outx;
    assign o_new_y       = r_outy;
    assign o_converged   = r_conv;

endmodule
